// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the text console writer.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ----- design/tcw_pkg.sv -----
// ----------------------------------------------------------------------------
// tcw_pkg
// Screen geometry, codes, types and structs shared by the console writer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tcw_pkg;

	localparam int ROWS       = 25;
	localparam int COLS       = 80;
	localparam int CELLS      = ROWS * COLS;
	localparam int MOVE_CELLS = (ROWS - 1) * COLS;
	localparam int ADDR_W     = $clog2(CELLS);
	localparam int ROW_W      = 5;
	localparam int COL_W      = 7;
	localparam int CELL_W     = 16;
	localparam int LEFT_W     = 16;
	localparam int CHAR_W     = 8;
	localparam int IDX_W      = 11;
	localparam int FUNC_W     = 2;

	localparam logic [CHAR_W-1:0] NEWLINE     = 8'd10;
	localparam logic [CELL_W-1:0] BLANK_RESET = 16'h0A00;

	localparam logic [FUNC_W-1:0] FUNC_PUT   = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_SCROLL,
		ST_SCROLL_END,
		ST_FILL,
		ST_PUT_RD,
		ST_PUT_WR,
		ST_RD_ISSUE,
		ST_RD_DATA,
		ST_DONE
	} tcw_state_t;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [CHAR_W-1:0] char_code;
		logic [LEFT_W-1:0] chars_left;
		logic [IDX_W-1:0]  cell_index;
	} tcw_item_t;

	typedef struct packed {
		logic [ROW_W-1:0]  cursor_row;
		logic [COL_W-1:0]  cursor_col;
		logic [CELL_W-1:0] read_data;
		logic              scrolled;
	} tcw_res_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [CELL_W-1:0] wdata;
		logic [ADDR_W-1:0] raddr;
	} tcw_ram_req_t;

endpackage

// ----- design/tcw_ram.sv -----
// ----------------------------------------------------------------------------
// tcw_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- design/tcw_ctrl.sv -----
// ----------------------------------------------------------------------------
// tcw_ctrl
// Sequencer, cursor state and shared address adder of the console writer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tcw_ctrl
	import tcw_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  tcw_item_t         item,
	input  logic [CELL_W-1:0] blank_cell,
	input  logic              out_free,
	output logic              res_valid,
	output tcw_res_t          res,
	output tcw_ram_req_t      ram_req,
	input  logic [CELL_W-1:0] rdata
);

	tcw_state_t state_q, state_d;

	logic [ADDR_W-1:0] cnt_q;
	logic [ROW_W-1:0]  row_q;
	logic [COL_W-1:0]  col_q;
	logic [ADDR_W-1:0] base_q;
	logic [FUNC_W-1:0] func_q;
	logic [CHAR_W-1:0] code_q;
	logic              nl_q;
	logic              fill_q;
	logic [IDX_W-1:0]  idx_q;
	logic [CELL_W-1:0] data_q;
	logic              scr_q;
	logic              mv_vld_s1;
	logic [ADDR_W-1:0] mv_addr_s1;

	logic              accept;
	logic              in_nl;
	logic              wrap;
	logic              last_row;
	logic              idx_ok;
	logic [ADDR_W-1:0] add_a, add_b, add_sum;

	assign accept   = in_valid && in_ready;
	assign in_nl    = (item.char_code == NEWLINE);
	assign wrap     = (col_q == COL_W'(COLS)) || in_nl;
	assign last_row = (row_q == ROW_W'(ROWS - 1));
	assign idx_ok   = (idx_q < IDX_W'(CELLS));

	// One adder forms every computed address: the source row during a
	// scroll, and the cursor cell otherwise.
	assign add_a   = (state_q == ST_SCROLL) ? cnt_q : base_q;
	assign add_b   = (state_q == ST_SCROLL) ? ADDR_W'(COLS) : ADDR_W'(col_q);
	assign add_sum = add_a + add_b;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_INIT: begin
				if (cnt_q == ADDR_W'(CELLS - 1)) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (accept) begin
					case (item.func)
						FUNC_PUT: begin
							if (wrap && last_row) state_d = ST_SCROLL;
							else if (in_nl)       state_d = ST_DONE;
							else                  state_d = ST_PUT_RD;
						end
						FUNC_CLEAR: state_d = ST_FILL;
						FUNC_READ:  state_d = ST_RD_ISSUE;
						default:    state_d = ST_DONE;
					endcase
				end
			end
			ST_SCROLL: begin
				if (cnt_q == ADDR_W'(MOVE_CELLS - 1)) state_d = ST_SCROLL_END;
			end
			ST_SCROLL_END: begin
				if (fill_q)    state_d = ST_FILL;
				else if (nl_q) state_d = ST_DONE;
				else           state_d = ST_PUT_RD;
			end
			ST_FILL: begin
				if (cnt_q == ADDR_W'(CELLS - 1)) begin
					state_d = (func_q == FUNC_PUT && !nl_q) ? ST_PUT_RD : ST_DONE;
				end
			end
			ST_PUT_RD:   state_d = ST_PUT_WR;
			ST_PUT_WR:   state_d = ST_DONE;
			ST_RD_ISSUE: state_d = ST_RD_DATA;
			ST_RD_DATA:  state_d = ST_DONE;
			ST_DONE: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready      = (state_q == ST_IDLE);
		res_valid     = (state_q == ST_DONE) && out_free;
		ram_req.we    = 1'b0;
		ram_req.waddr = '0;
		ram_req.wdata = '0;
		ram_req.raddr = add_sum;
		if (mv_vld_s1) begin
			ram_req.we    = 1'b1;
			ram_req.waddr = mv_addr_s1;
			ram_req.wdata = rdata;
		end
		case (state_q)
			ST_INIT: begin
				ram_req.we    = 1'b1;
				ram_req.waddr = cnt_q;
				ram_req.wdata = BLANK_RESET;
			end
			ST_FILL: begin
				ram_req.we    = 1'b1;
				ram_req.waddr = cnt_q;
				ram_req.wdata = blank_cell;
			end
			ST_PUT_WR: begin
				ram_req.we    = 1'b1;
				ram_req.waddr = add_sum;
				ram_req.wdata = {rdata[CELL_W-1:CHAR_W], code_q};
			end
			ST_RD_ISSUE: begin
				ram_req.raddr = idx_ok ? ADDR_W'(idx_q) : '0;
			end
			default: begin
			end
		endcase
	end

	assign res.cursor_row = row_q;
	assign res.cursor_col = col_q;
	assign res.read_data  = data_q;
	assign res.scrolled   = scr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_INIT;
			cnt_q     <= '0;
			row_q     <= ROW_W'(ROWS - 1);
			col_q     <= '0;
			base_q    <= ADDR_W'(MOVE_CELLS);
			mv_vld_s1 <= 1'b0;
			scr_q     <= 1'b0;
		end else begin
			state_q   <= state_d;
			mv_vld_s1 <= (state_q == ST_SCROLL);
			case (state_q)
				ST_INIT, ST_SCROLL, ST_FILL: begin
					cnt_q <= cnt_q + 1'b1;
				end
				ST_SCROLL_END: begin
					cnt_q <= ADDR_W'(MOVE_CELLS);
				end
				ST_PUT_WR: begin
					col_q <= col_q + 1'b1;
				end
				default: begin
				end
			endcase
			if (accept) begin
				cnt_q <= '0;
				scr_q <= (item.func == FUNC_PUT) && wrap && last_row;
				case (item.func)
					FUNC_PUT: begin
						if (wrap) begin
							col_q <= '0;
							if (!last_row) begin
								row_q  <= row_q + 1'b1;
								base_q <= base_q + ADDR_W'(COLS);
							end
						end
					end
					FUNC_CLEAR: begin
						row_q  <= '0;
						col_q  <= '0;
						base_q <= '0;
					end
					default: begin
					end
				endcase
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		mv_addr_s1 <= cnt_q;
		if (accept) begin
			func_q <= item.func;
			code_q <= item.char_code;
			nl_q   <= in_nl;
			fill_q <= (item.chars_left < LEFT_W'(COLS));
			idx_q  <= item.cell_index;
			data_q <= '0;
		end else if (state_q == ST_RD_DATA) begin
			data_q <= idx_ok ? rdata : '0;
		end
	end

	`ASSERT_ALWAYS(a_cursor_range, clk, arst_n, (col_q <= COL_W'(COLS)) && (row_q <= ROW_W'(ROWS - 1)))
	`ASSERT_ALWAYS(a_row_base, clk, arst_n, base_q == ADDR_W'(row_q * COLS))
	`ASSERT_NEXT(a_move_drained, clk, arst_n, state_q == ST_SCROLL_END, !mv_vld_s1)

endmodule

// ----- design/text_console_writer_core.sv -----
// ----------------------------------------------------------------------------
// text_console_writer_core
// 80 by 25 text console: put character, clear screen and cell read-back.
// ----------------------------------------------------------------------------
// After reset the block first sweeps the 2000-cell screen memory to the
// default blank cell 0x0A00, one cell a cycle, and takes no beat during
// the sweep; blank_cell writes are taken meanwhile. One beat is handled
// at a time and every beat yields exactly one result beat. A plain put
// passes through the states PUT_RD and PUT_WR and a read through RD_ISSUE
// and RD_DATA, set by the registered read of the single-port-write screen
// RAM (read the cell, then write it back with its attribute kept). A put
// that wraps on the last row scrolls: the shared address adder walks the
// 1920 cells of rows 1 to 24 through the RAM, one cell moved per cycle,
// and then the 80 cells of the bottom line are refilled with blank_cell
// (that happens only when chars_left is below 80). A clear writes all 2000
// cells. The result register lets the next beat in while the previous
// result still waits on m_tready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module text_console_writer_core
	import tcw_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// Input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // char_code[7:0], chars_left[23:8], cell_index[34:24]
	input  logic [1:0]  s_tuser,  // func[1:0]
	// Result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // cursor_row[4:0], cursor_col[11:5], read_data[27:12],
	                              // scrolled[28]
	// Configuration
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data
);

	tcw_item_t         item;
	tcw_res_t          res;
	tcw_ram_req_t      ram_req;
	logic [CELL_W-1:0] rdata;
	logic [CELL_W-1:0] blank_q;
	logic              res_valid;
	logic              out_free;
	logic              m_tvalid_q;
	logic [31:0]       m_tdata_q;

	// Unpack the input beat into its fields.
	assign item.func       = s_tuser;
	assign item.char_code  = s_tdata[7:0];
	assign item.chars_left = s_tdata[23:8];
	assign item.cell_index = s_tdata[34:24];

	// The blank cell used by clear and by the scrolled-in bottom line.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blank_q <= BLANK_RESET;
		end else if (cfg_wr_en) begin
			blank_q <= cfg_wr_data;
		end
	end

	tcw_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.item       (item),
		.blank_cell (blank_q),
		.out_free   (out_free),
		.res_valid  (res_valid),
		.res        (res),
		.ram_req    (ram_req),
		.rdata      (rdata)
	);

	tcw_ram #(
		.WIDTH (CELL_W),
		.DEPTH (CELLS)
	) u_screen (
		.clk   (clk),
		.we    (ram_req.we),
		.waddr (ram_req.waddr),
		.wdata (ram_req.wdata),
		.raddr (ram_req.raddr),
		.rdata (rdata)
	);

	// Result register: holds a finished beat until the sink takes it.
	assign out_free = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_valid) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			m_tdata_q <= {3'b000, res.scrolled, res.read_data, res.cursor_col, res.cursor_row};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

// ----- sim/text_console_writer_core_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_writer_core_test
// Self-checking stream testbench for the 80 by 25 text console writer.
// ----------------------------------------------------------------------------
// A driver feeds put, clear, read and unused-code beats from a queue. A shadow
// copy of the screen, cursor and blank cell works out each expected status
// beat, and a monitor checks every result beat against the oldest one. The run
// opens with directed corner cases and then goes through random phases that
// mostly hold well-formed write calls. The blank cell changes between phases.
// ----------------------------------------------------------------------------

module text_console_writer_core_test;
	import tcw_pkg::*;

	// Selector value that the block has no operation for.
	localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
	// Cycles without any beat before the run is declared hung. It outlasts a
	// scroll with a refill, a clear and the start-up sweep, plus the longest
	// sender gap and the longest receiver stall.
	localparam int QUIET_LIMIT = 20000;
	localparam int PHASES = 6;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata = '0;   // char_code[7:0], chars_left[23:8], cell_index[34:24]
	logic [1:0]  s_tuser = '0;   // func[1:0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;        // cursor_row[4:0], cursor_col[11:5], read_data[27:12],
	                             // scrolled[28]
	logic        cfg_wr_en = 1'b0;
	logic [15:0] cfg_wr_data = '0;

	text_console_writer_core i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	always #5 clk = ~clk;

	// Shadow state of the console, updated once per accepted input beat.
	logic [CELL_W-1:0] shadow_screen [CELLS];
	int                shadow_row;
	int                shadow_col;
	logic [CELL_W-1:0] shadow_blank;

	tcw_item_t pending_ops[$];       // beats not yet presented to the block
	tcw_res_t  expected_status[$];   // status beats the block still owes
	tcw_item_t cur_item;             // beat currently on the input bus

	int  error_count = 0;
	int  beats_in = 0;
	int  beats_out = 0;
	int  put_count = 0;
	int  scroll_count = 0;
	int  refill_count = 0;
	int  read_count = 0;
	int  clear_count = 0;
	int  blank_writes = 0;
	int  quiet_cycles = 0;
	int  gap_left = 0;
	int  stall_left = 0;
	bit  gaps_on = 1'b0;

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Applies one operation to the shadow console and returns the status beat
	// that the block must send back for it.
	function automatic tcw_res_t predict_console_status(tcw_item_t op);
		tcw_res_t res;
		int       at;
		int       i;
		bit       is_newline;
		res = '0;
		case (op.func)
			FUNC_PUT: begin
				put_count++;
				is_newline = (op.char_code == NEWLINE);
				// A newline or a full line wraps first; on the bottom row the
				// wrap scrolls, and the new bottom line is only blanked when
				// the caller's write has fewer than a line of characters left.
				if (shadow_col >= COLS || is_newline) begin
					if (shadow_row >= ROWS - 1) begin
						for (i = 0; i < MOVE_CELLS; i++)
							shadow_screen[i] = shadow_screen[i + COLS];
						if (op.chars_left < COLS) begin
							for (i = MOVE_CELLS; i < CELLS; i++)
								shadow_screen[i] = shadow_blank;
							refill_count++;
						end
						res.scrolled = 1'b1;
						scroll_count++;
					end else begin
						shadow_row++;
					end
					shadow_col = 0;
				end
				// The attribute byte of the target cell survives the store.
				if (!is_newline) begin
					at = shadow_row * COLS + shadow_col;
					shadow_screen[at] = {shadow_screen[at][CELL_W-1:CHAR_W], op.char_code};
					shadow_col++;
				end
			end
			FUNC_CLEAR: begin
				clear_count++;
				for (i = 0; i < CELLS; i++)
					shadow_screen[i] = shadow_blank;
				shadow_row = 0;
				shadow_col = 0;
			end
			FUNC_READ: begin
				read_count++;
				if (op.cell_index < CELLS)
					res.read_data = shadow_screen[op.cell_index];
			end
			default: begin
				// The unused selector leaves everything as it is.
			end
		endcase
		res.cursor_row = shadow_row[ROW_W-1:0];
		res.cursor_col = shadow_col[COL_W-1:0];
		return res;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch at %0t ns: %s got 0x%0h, want 0x%0h", $time, what, got, want);
		error_count++;
	endtask

	// Driver: predicts on every accepted beat, then presents the next pending
	// beat, possibly after a random gap.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			gap_left <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				expected_status.push_back(predict_console_status(cur_item));
				beats_in++;
			end
			if (!s_tvalid || s_tready) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					s_tvalid <= 1'b0;
				end else if (pending_ops.size() > 0) begin
					cur_item = pending_ops.pop_front();
					s_tdata  <= {5'b0, cur_item.cell_index, cur_item.chars_left,
					             cur_item.char_code};
					s_tuser  <= cur_item.func;
					s_tvalid <= 1'b1;
					gap_left <= gaps_on ? pick_gap() : 0;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver: drops m_tready for random stretches while gaps are enabled.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready   <= 1'b0;
			stall_left <= 0;
		end else if (stall_left > 0) begin
			m_tready   <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (gaps_on && $urandom_range(0, 3) == 0) begin : start_stall
			int len;
			len = pick_gap();
			m_tready   <= (len == 0);
			stall_left <= (len > 0) ? len - 1 : 0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Monitor: every result beat is checked field by field against the oldest
	// outstanding expectation.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin : check_beat
			tcw_res_t got;
			tcw_res_t want;
			got.cursor_row = m_tdata[4:0];
			got.cursor_col = m_tdata[11:5];
			got.read_data  = m_tdata[27:12];
			got.scrolled   = m_tdata[28];
			beats_out++;
			if (expected_status.size() == 0) begin
				report_mismatch("result beat with nothing outstanding", m_tdata, 0);
			end else begin
				want = expected_status.pop_front();
				if (got.cursor_row !== want.cursor_row)
					report_mismatch("cursor_row", int'(got.cursor_row),
					                int'(want.cursor_row));
				if (got.cursor_col !== want.cursor_col)
					report_mismatch("cursor_col", int'(got.cursor_col),
					                int'(want.cursor_col));
				if (got.read_data !== want.read_data)
					report_mismatch("read_data", int'(got.read_data),
					                int'(want.read_data));
				if (got.scrolled !== want.scrolled)
					report_mismatch("scrolled", int'(got.scrolled), int'(want.scrolled));
			end
		end
	end

	// Counts cycles in which no beat moves on either side.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin : watchdog
		do
			@(posedge clk);
		while (quiet_cycles < QUIET_LIMIT);
		$display("hang: no beat for %0d cycles, %0d results outstanding",
		         QUIET_LIMIT, expected_status.size());
		$display("FAILURE");
		$finish;
	end

	task automatic queue_op(logic [FUNC_W-1:0] func, logic [CHAR_W-1:0] code,
	                        logic [LEFT_W-1:0] left, logic [IDX_W-1:0] idx);
		tcw_item_t op;
		op.func       = func;
		op.char_code  = code;
		op.chars_left = left;
		op.cell_index = idx;
		pending_ops.push_back(op);
	endtask

	// One write call of the caller: chars_left counts down to 1, newlines are
	// sprinkled in at the given percentage and often end the call.
	task automatic queue_write_call(int len, int newline_pct);
		logic [CHAR_W-1:0] code;
		int k;
		for (k = 0; k < len; k++) begin
			code = CHAR_W'($urandom_range(0, 255));
			if ($urandom_range(0, 99) < newline_pct ||
			    (k == len - 1 && $urandom_range(0, 99) < 60))
				code = NEWLINE;
			else if (code == NEWLINE)
				code = 8'h20;
			queue_op(FUNC_PUT, code, LEFT_W'(len - k), IDX_W'($urandom_range(0, 2047)));
		end
	endtask

	// Reads lean toward the lower rows, where new text lands and scrolls up.
	task automatic queue_reads(int n);
		int r;
		int k;
		logic [IDX_W-1:0] idx;
		for (k = 0; k < n; k++) begin
			r = $urandom_range(0, 99);
			if (r < 40)
				idx = IDX_W'($urandom_range(MOVE_CELLS - COLS, CELLS - 1));
			else if (r < 75)
				idx = IDX_W'($urandom_range(0, CELLS - 1));
			else if (r < 90)
				idx = IDX_W'($urandom_range(0, 5 * COLS - 1));
			else
				idx = IDX_W'($urandom_range(CELLS, 2047));
			queue_op(FUNC_READ, CHAR_W'($urandom_range(0, 255)),
			         LEFT_W'($urandom_range(0, 65535)), idx);
		end
	endtask

	// A beat with every field random, the unused selector included.
	task automatic queue_noise();
		queue_op(FUNC_W'($urandom_range(0, 3)), CHAR_W'($urandom_range(0, 255)),
		         LEFT_W'($urandom_range(0, 65535)), IDX_W'($urandom_range(0, 2047)));
	endtask

	// Fills a phase with about n beats; a write call is cut short at the end
	// of the phase.
	task automatic queue_random_phase(int n);
		int stop;
		int pick;
		int room;
		int len;
		stop = pending_ops.size() + n;
		while (pending_ops.size() < stop) begin
			room = stop - pending_ops.size();
			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				len = $urandom_range(1, 30);
				queue_write_call((len < room) ? len : room, 8);
			end else if (pick < 65) begin
				len = $urandom_range(COLS, 200);
				queue_write_call((len < room) ? len : room, 2);
			end else if (pick < 85)
				queue_reads($urandom_range(1, 4));
			else if (pick < 88)
				queue_op(FUNC_CLEAR, CHAR_W'($urandom_range(0, 255)),
				         LEFT_W'($urandom_range(0, 65535)), IDX_W'($urandom_range(0, 2047)));
			else
				queue_noise();
		end
	endtask

	// Waits until the sender has nothing left and every result is back.
	task automatic wait_drained();
		while (pending_ops.size() != 0 || expected_status.size() != 0 || s_tvalid)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// The register is to be written only while the block is idle; this task does not enforce it.
	task automatic set_blank(logic [15:0] value);
		@(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en    <= 1'b0;
		shadow_blank = value;
		blank_writes++;
	endtask

	initial begin : stimulus
		logic [15:0] blank_plan [PHASES];
		int p;
		for (p = 0; p < CELLS; p++)
			shadow_screen[p] = BLANK_RESET;
		shadow_row   = ROWS - 1;
		shadow_col   = 0;
		shadow_blank = BLANK_RESET;
		blank_plan = '{16'h0000, 16'h0000, 16'h0A00, 16'h0000, 16'hFFFF, 16'h0000};
		blank_plan[1] = 16'($urandom_range(0, 65535));
		blank_plan[3] = 16'($urandom_range(0, 65535));
		blank_plan[5] = 16'($urandom_range(0, 65535));

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// The block sweeps its memory after reset and takes no beat meanwhile,
		// but the register write is allowed. Cells still start at the reset
		// blank, only later refills and clears use the new value.
		set_blank(16'hFFFF);

		// Directed corner cases, with the cursor still on the bottom row.
		@(negedge clk);
		queue_op(FUNC_READ, 8'h00, 16'd1, 11'd0);
		queue_op(FUNC_READ, 8'hFF, 16'hFFFF, IDX_W'(CELLS - 1));
		queue_op(FUNC_READ, 8'h00, 16'd1, IDX_W'(CELLS));   // first index past the screen
		queue_op(FUNC_READ, 8'h00, 16'd1, 11'h7FF);
		queue_op(FUNC_UNUSED, 8'hFF, 16'hFFFF, 11'h7FF);
		queue_op(FUNC_PUT, 8'h00, 16'd1, 11'd0);
		queue_op(FUNC_PUT, 8'hFF, 16'hFFFF, 11'h7FF);
		// Long write: the scroll keeps the old bottom line in place.
		queue_op(FUNC_PUT, NEWLINE, 16'hFFFF, 11'd0);
		queue_op(FUNC_READ, 8'h00, 16'd1, IDX_W'(MOVE_CELLS - COLS + 1));
		queue_op(FUNC_READ, 8'h00, 16'd1, IDX_W'(MOVE_CELLS + 1));
		// Exactly a line left still keeps the bottom line, one less refills it.
		queue_op(FUNC_PUT, NEWLINE, LEFT_W'(COLS), 11'd0);
		queue_op(FUNC_PUT, NEWLINE, LEFT_W'(COLS - 1), 11'd0);
		queue_op(FUNC_READ, 8'h00, 16'd1, IDX_W'(MOVE_CELLS));
		// A character on a refilled cell keeps the blank's attribute byte.
		queue_op(FUNC_PUT, 8'h41, 16'd0, 11'd0);
		queue_op(FUNC_PUT, NEWLINE, 16'd0, 11'd0);        // zero length refills too
		queue_op(FUNC_CLEAR, 8'h00, 16'd0, 11'd0);
		queue_op(FUNC_READ, 8'h00, 16'd1, 11'd0);
		// Off the bottom row a newline just moves the cursor down.
		queue_op(FUNC_PUT, NEWLINE, 16'd1, 11'd0);
		queue_op(FUNC_PUT, 8'h7E, 16'd1, 11'd0);
		queue_op(FUNC_READ, 8'h00, 16'd1, IDX_W'(COLS));

		// Each phase starts only once every result of the previous one is
		// back, so the sender pauses with the block fully drained. One phase
		// runs with no gaps and no stalls at all.
		for (p = 0; p < PHASES; p++) begin
			wait_drained();
			set_blank(blank_plan[p]);
			@(negedge clk);
			gaps_on <= (p != 1);
			queue_random_phase(115);
		end

		wait_drained();
		if (expected_status.size() != 0)
			report_mismatch("results never delivered", expected_status.size(), 0);

		$display("covered %0d beats in, %0d out: %0d puts, %0d scrolls (%0d refilled),",
		         beats_in, beats_out, put_count, scroll_count, refill_count);
		$display("%0d reads, %0d clears, %0d blank cell settings, %0d mismatches",
		         read_count, clear_count, blank_writes, error_count);
		if (error_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
